### design/bresenham_line_3d_stepper_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis line stepper
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_3D_STEPPER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_3D_STEPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BL3D_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("Stepper assertion failed.");
`define BL3D_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("Stepper assertion failed.");
`else
`define BL3D_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BL3D_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/bl3d_pkg.sv
// ----------------------------------------------------------------------------
// Line stepper package
// Axis and request codes, the control struct and the minor axis mapping.
// ----------------------------------------------------------------------------
package bl3d_pkg;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [2:0] dir;
        axis_t      major;
    } bl3d_ctrl_t;

    function automatic axis_t minor_a(input axis_t major);
        axis_t res;
        begin
            case (major)
                AXIS_Y:  res = AXIS_X;
                default: res = AXIS_Y;
            endcase
            return res;
        end
    endfunction

    function automatic axis_t minor_b(input axis_t major);
        axis_t res;
        begin
            case (major)
                AXIS_Z:  res = AXIS_X;
                default: res = AXIS_Z;
            endcase
            return res;
        end
    endfunction

endpackage

### design/bl3d_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries load and tick transactions into the stepper.
// ----------------------------------------------------------------------------
interface bl3d_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (
        output valid, req_type, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

### design/bl3d_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result transaction for every request.
// ----------------------------------------------------------------------------
interface bl3d_res_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [2:0]                   step_mask;
    logic [2:0]                   dir_mask;
    logic                         stepped;
    logic                         last;
    logic                         busy_res;

    modport source (
        output valid, pos_x, pos_y, pos_z, step_mask, dir_mask, stepped, last, busy_res,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, step_mask, dir_mask, stepped, last, busy_res,
        output ready
    );
endinterface

### design/bl3d_setup.sv
// ----------------------------------------------------------------------------
// Line setup
// Works out distances, directions, the driving axis and initial error terms.
// ----------------------------------------------------------------------------
module bl3d_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] start_pt [3],
    input  logic signed [COORD_BITS-1:0] end_pt [3],
    output logic [COORD_BITS:0]          delta_major,
    output logic [COORD_BITS+2:0]        two_delta_a,
    output logic [COORD_BITS+2:0]        two_delta_b,
    output logic signed [COORD_BITS+2:0] err_a,
    output logic signed [COORD_BITS+2:0] err_b,
    output bl3d_pkg::bl3d_ctrl_t         ctrl
);

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] diff [3];
    logic [DW-1:0]        delta [3];
    logic [DW-1:0]        delta_a;
    logic [DW-1:0]        delta_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = DW'(end_pt[i]) - DW'(start_pt[i]);
            delta[i]    = diff[i][DW-1] ? DW'(-diff[i]) : diff[i];
            ctrl.dir[i] = !(end_pt[i] > start_pt[i]);
        end

        if (delta[0] >= delta[1] && delta[0] >= delta[2])
        begin
            ctrl.major = bl3d_pkg::AXIS_X;
        end
        else if (delta[1] >= delta[2])
        begin
            ctrl.major = bl3d_pkg::AXIS_Y;
        end
        else
        begin
            ctrl.major = bl3d_pkg::AXIS_Z;
        end

        case (ctrl.major)
            bl3d_pkg::AXIS_Y:
            begin
                delta_major = delta[1];
                delta_a     = delta[0];
                delta_b     = delta[2];
            end
            bl3d_pkg::AXIS_Z:
            begin
                delta_major = delta[2];
                delta_a     = delta[1];
                delta_b     = delta[0];
            end
            default:
            begin
                delta_major = delta[0];
                delta_a     = delta[1];
                delta_b     = delta[2];
            end
        endcase

        two_delta_a = {1'b0, delta_a, 1'b0};
        two_delta_b = {1'b0, delta_b, 1'b0};
        err_a       = $signed(two_delta_a) - $signed({2'b00, delta_major});
        err_b       = $signed(two_delta_b) - $signed({2'b00, delta_major});
    end

endmodule

### design/bresenham_line_3d_stepper_core.sv
// Requests pass through an input register, then an output register when it is free.
// One transaction per cycle unless results stall; the line state updates in a single pass.
// Each result is held in an output register while the next request is taken.
// Reset clears the position to the origin, all error terms and counts to zero,
// and leaves the stepper idle with the x axis as the driving axis.
// ----------------------------------------------------------------------------
// Three-axis line stepper core
// Loads a line between two points and issues one Bresenham step per tick while a line is active.
// ----------------------------------------------------------------------------
`include "bresenham_line_3d_stepper_core_defines.svh"

module bresenham_line_3d_stepper_core #(
    parameter int COORD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bl3d_req_if.sink   req,
    bl3d_res_if.source res
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic                         in_valid_reg;
    logic                         in_type_reg;
    logic signed [COORD_BITS-1:0] in_start_reg [3];
    logic signed [COORD_BITS-1:0] in_end_reg [3];

    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic signed [COORD_BITS-1:0] pos_next [3];
    logic [EW-1:0]                two_dmaj_reg, two_dmaj_next;
    logic [EW-1:0]                two_da_reg, two_da_next;
    logic [EW-1:0]                two_db_reg, two_db_next;
    logic signed [EW-1:0]         err_a_reg, err_a_next;
    logic signed [EW-1:0]         err_b_reg, err_b_next;
    logic [DW-1:0]                steps_left_reg, steps_left_next;
    bl3d_pkg::bl3d_ctrl_t         ctrl_reg, ctrl_next;
    logic                         active_reg, active_next;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_pos_reg [3];
    logic [2:0]                   out_step_reg, out_step_next;
    logic                         out_stepped_reg, out_stepped_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_busy_reg;
    logic [2:0]                   out_dir_reg;

    logic                         req_acc;
    logic                         fire;

    logic [DW-1:0]                su_delta_major;
    logic [EW-1:0]                su_two_da;
    logic [EW-1:0]                su_two_db;
    logic signed [EW-1:0]         su_err_a;
    logic signed [EW-1:0]         su_err_b;
    bl3d_pkg::bl3d_ctrl_t         su_ctrl;

    bl3d_pkg::axis_t              ax_a;
    bl3d_pkg::axis_t              ax_b;
    logic                         a_moves;
    logic                         b_moves;
    logic [2:0]                   tick_mask;

    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign req_acc   = req.valid && req.ready;
    assign req.ready = !in_valid_reg || fire;

    bl3d_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_pt    (in_start_reg),
        .end_pt      (in_end_reg),
        .delta_major (su_delta_major),
        .two_delta_a (su_two_da),
        .two_delta_b (su_two_db),
        .err_a       (su_err_a),
        .err_b       (su_err_b),
        .ctrl        (su_ctrl)
    );

    assign ax_a      = bl3d_pkg::minor_a(ctrl_reg.major);
    assign ax_b      = bl3d_pkg::minor_b(ctrl_reg.major);
    assign a_moves   = !err_a_reg[EW-1];
    assign b_moves   = !err_b_reg[EW-1];
    assign tick_mask = (3'b001 << ctrl_reg.major)
                     | (a_moves ? (3'b001 << ax_a) : 3'b000)
                     | (b_moves ? (3'b001 << ax_b) : 3'b000);

    always_comb
    begin
        pos_next         = pos_reg;
        two_dmaj_next    = two_dmaj_reg;
        two_da_next      = two_da_reg;
        two_db_next      = two_db_reg;
        err_a_next       = err_a_reg;
        err_b_next       = err_b_reg;
        steps_left_next  = steps_left_reg;
        ctrl_next        = ctrl_reg;
        active_next      = active_reg;
        out_step_next    = 3'b000;
        out_stepped_next = 1'b0;
        out_last_next    = 1'b0;

        if (in_type_reg == bl3d_pkg::REQ_LOAD)
        begin
            pos_next        = in_start_reg;
            two_dmaj_next   = {1'b0, su_delta_major, 1'b0};
            two_da_next     = su_two_da;
            two_db_next     = su_two_db;
            err_a_next      = su_err_a;
            err_b_next      = su_err_b;
            steps_left_next = su_delta_major;
            ctrl_next       = su_ctrl;
            active_next     = (su_delta_major != '0);
            out_last_next   = (su_delta_major == '0);
        end
        else if (active_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (tick_mask[i])
                begin
                    pos_next[i] = pos_reg[i]
                                + (ctrl_reg.dir[i] ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
                end
            end
            err_a_next       = err_a_reg - (a_moves ? two_dmaj_reg : '0) + two_da_reg;
            err_b_next       = err_b_reg - (b_moves ? two_dmaj_reg : '0) + two_db_reg;
            steps_left_next  = steps_left_reg - DW'(1);
            active_next      = (steps_left_reg != DW'(1));
            out_step_next    = tick_mask;
            out_stepped_next = 1'b1;
            out_last_next    = (steps_left_reg == DW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_reg     <= 1'b0;
            ctrl_reg       <= '0;
            steps_left_reg <= '0;
            two_dmaj_reg   <= '0;
            two_da_reg     <= '0;
            two_db_reg     <= '0;
            err_a_reg      <= '0;
            err_b_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (req_acc)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                active_reg     <= active_next;
                ctrl_reg       <= ctrl_next;
                steps_left_reg <= steps_left_next;
                two_dmaj_reg   <= two_dmaj_next;
                two_da_reg     <= two_da_next;
                two_db_reg     <= two_db_next;
                err_a_reg      <= err_a_next;
                err_b_reg      <= err_b_next;
                pos_reg        <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            in_type_reg     <= req.req_type;
            in_start_reg[0] <= req.start_x;
            in_start_reg[1] <= req.start_y;
            in_start_reg[2] <= req.start_z;
            in_end_reg[0]   <= req.end_x;
            in_end_reg[1]   <= req.end_y;
            in_end_reg[2]   <= req.end_z;
        end

        if (fire)
        begin
            out_pos_reg     <= pos_next;
            out_step_reg    <= out_step_next;
            out_stepped_reg <= out_stepped_next;
            out_last_reg    <= out_last_next;
            out_busy_reg    <= active_next;
        end
    end

    // The direction mask is captured with each result so that a later load
    // cannot change a result that is still waiting.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_dir_reg <= ctrl_next.dir;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.pos_x     = out_pos_reg[0];
    assign res.pos_y     = out_pos_reg[1];
    assign res.pos_z     = out_pos_reg[2];
    assign res.step_mask = out_step_reg;
    assign res.dir_mask  = out_dir_reg;
    assign res.stepped   = out_stepped_reg;
    assign res.last      = out_last_reg;
    assign res.busy_res  = out_busy_reg;

    `BL3D_ASSERT_IMP(a_active_matches_count, clk, rst_n, 1'b1, active_reg == (steps_left_reg != '0))
    `BL3D_ASSERT_NXT(a_idle_tick_no_step, clk, rst_n, fire && in_type_reg == bl3d_pkg::REQ_TICK && !active_reg, out_step_reg == 3'b000 && !out_stepped_reg)
    `BL3D_ASSERT_IMP(a_last_excludes_busy, clk, rst_n, out_valid_reg, !(out_last_reg && out_busy_reg))
    `BL3D_ASSERT_IMP(a_stepped_matches_mask, clk, rst_n, out_valid_reg, out_stepped_reg == (out_step_reg != 3'b000))

endmodule

### dv/tb_bresenham_line_3d_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-axis line stepper core
// Drives load and tick transactions through the request channel and
// predicts every point that the stepper reports. A table of directed
// transactions comes first, then random lines under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_bresenham_line_3d_stepper_core;

    typedef struct packed {
        logic            req_type;
        logic [2:0][15:0] from;
        logic [2:0][15:0] to;
    } line_req_t;

    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [2:0]       step_mask;
        logic [2:0]       dir_mask;
        logic             stepped;
        logic             last;
        logic             busy_res;
    } point_res_t;

    typedef struct {
        line_req_t  rq;
        bit         typed;
        point_res_t want;
    } table_row_t;

    logic clk;
    logic rst_n;

    bl3d_req_if #(.COORD_BITS(16)) req_bus ();
    bl3d_res_if #(.COORD_BITS(16)) res_bus ();

    bresenham_line_3d_stepper_core #(
        .COORD_BITS(16)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    logic signed [15:0] cur_pos [3];
    logic [16:0]        span [3];
    logic signed [18:0] err_term [2];
    logic [16:0]        steps_to_go;
    logic [2:0]         dir_bits;
    bl3d_pkg::axis_t    drive_axis;
    logic               line_on;

    point_res_t pending_points [$];
    table_row_t rows [$];
    int         n_sent;
    int         n_bad;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_token;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("tb_bresenham_line_3d_stepper_core NOT OK");
        $finish;
    end

    function automatic logic [1:0][1:0] minor_pair(input bl3d_pkg::axis_t m);
        logic [1:0][1:0] mp;
        case (m)
            bl3d_pkg::AXIS_X:
            begin
                mp[0] = bl3d_pkg::AXIS_Y;
                mp[1] = bl3d_pkg::AXIS_Z;
            end
            bl3d_pkg::AXIS_Y:
            begin
                mp[0] = bl3d_pkg::AXIS_X;
                mp[1] = bl3d_pkg::AXIS_Z;
            end
            default:
            begin
                mp[0] = bl3d_pkg::AXIS_Y;
                mp[1] = bl3d_pkg::AXIS_X;
            end
        endcase
        return mp;
    endfunction

    function automatic void move_one(input bl3d_pkg::axis_t ax);
        if (dir_bits[ax])
            cur_pos[ax] = cur_pos[ax] - 16'sd1;
        else
            cur_pos[ax] = cur_pos[ax] + 16'sd1;
    endfunction

    function automatic point_res_t snapshot(input logic [2:0] sm, input logic st,
                                            input logic la);
        point_res_t o;
        for (int k = 0; k < 3; k++)
            o.pos[k] = cur_pos[k];
        o.step_mask = sm;
        o.dir_mask  = dir_bits;
        o.stepped   = st;
        o.last      = la;
        o.busy_res  = line_on;
        return o;
    endfunction

    function automatic point_res_t trace_step(input line_req_t rq);
        logic [1:0][1:0] mn;
        logic [16:0]     dmaj;
        logic [2:0]      sm;
        int              d;
        int              e;
        if (rq.req_type == bl3d_pkg::REQ_LOAD)
        begin
            dir_bits = 3'b000;
            for (int k = 0; k < 3; k++)
            begin
                d = int'($signed(rq.to[k])) - int'($signed(rq.from[k]));
                span[k] = 17'(d < 0 ? -d : d);
                if (!($signed(rq.to[k]) > $signed(rq.from[k])))
                    dir_bits[k] = 1'b1;
                cur_pos[k] = rq.from[k];
            end
            if (span[0] >= span[1] && span[0] >= span[2])
                drive_axis = bl3d_pkg::AXIS_X;
            else if (span[1] >= span[2])
                drive_axis = bl3d_pkg::AXIS_Y;
            else
                drive_axis = bl3d_pkg::AXIS_Z;
            mn   = minor_pair(drive_axis);
            dmaj = span[drive_axis];
            for (int i = 0; i < 2; i++)
                err_term[i] = 19'(2 * int'(span[mn[i]]) - int'(dmaj));
            steps_to_go = dmaj;
            line_on     = (steps_to_go != 0);
            return snapshot(3'b000, 1'b0, !line_on);
        end
        if (!line_on)
            return snapshot(3'b000, 1'b0, 1'b0);
        mn   = minor_pair(drive_axis);
        dmaj = span[drive_axis];
        move_one(drive_axis);
        sm = 3'b001 << drive_axis;
        for (int i = 0; i < 2; i++)
        begin
            e = int'(err_term[i]);
            if (e >= 0)
            begin
                move_one(mn[i]);
                sm[mn[i]] = 1'b1;
                e = e - 2 * int'(dmaj);
            end
            e = e + 2 * int'(span[mn[i]]);
            err_term[i] = 19'(e);
        end
        steps_to_go = steps_to_go - 17'd1;
        line_on     = (steps_to_go != 0);
        return snapshot(sm, 1'b1, !line_on);
    endfunction

    function automatic line_req_t load_req(input int sx, input int sy, input int sz,
                                           input int ex, input int ey, input int ez);
        line_req_t rq;
        rq.req_type = bl3d_pkg::REQ_LOAD;
        rq.from[0] = 16'(sx);
        rq.from[1] = 16'(sy);
        rq.from[2] = 16'(sz);
        rq.to[0]   = 16'(ex);
        rq.to[1]   = 16'(ey);
        rq.to[2]   = 16'(ez);
        return rq;
    endfunction

    function automatic line_req_t random_req(input logic kind);
        line_req_t rq;
        rq.req_type = kind;
        for (int k = 0; k < 3; k++)
        begin
            rq.from[k] = 16'($urandom);
            rq.to[k]   = 16'($urandom);
        end
        return rq;
    endfunction

    function automatic point_res_t pt(input int x, input int y, input int z, input int sm,
                                      input int dm, input int st, input int la,
                                      input int bu);
        point_res_t o;
        o.pos[0]    = 16'(x);
        o.pos[1]    = 16'(y);
        o.pos[2]    = 16'(z);
        o.step_mask = 3'(sm);
        o.dir_mask  = 3'(dm);
        o.stepped   = 1'(st);
        o.last      = 1'(la);
        o.busy_res  = 1'(bu);
        return o;
    endfunction

    task automatic add_row(input line_req_t rq, input bit typed, input point_res_t want);
        table_row_t r;
        r.rq    = rq;
        r.typed = typed;
        r.want  = want;
        rows.push_back(r);
    endtask

    task automatic offer(input line_req_t rq, input bit typed, input point_res_t want);
        point_res_t p;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rq.req_type;
        req_bus.start_x  <= rq.from[0];
        req_bus.start_y  <= rq.from[1];
        req_bus.start_z  <= rq.from[2];
        req_bus.end_x    <= rq.to[0];
        req_bus.end_y    <= rq.to[1];
        req_bus.end_z    <= rq.to[2];
        do
            @(posedge clk);
        while (!req_bus.ready);
        p = trace_step(rq);
        pending_points.push_back(typed ? want : p);
        n_sent++;
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
    endtask

    initial
    begin
        int hold_left;
        int hold_seen;
        res_bus.ready = 1'b0;
        hold_left     = 0;
        hold_seen     = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                res_bus.ready <= 1'b0;
            else if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = 300;
                res_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v,
                     got_v);
            n_bad++;
        end
    endtask

    always @(posedge clk)
    begin
        point_res_t want;
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: result transaction with nothing expected, pos %0d %0d %0d",
                         $time, res_bus.pos_x, res_bus.pos_y, res_bus.pos_z);
                n_bad++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("pos_x", $signed(want.pos[0]), res_bus.pos_x);
                check_field("pos_y", $signed(want.pos[1]), res_bus.pos_y);
                check_field("pos_z", $signed(want.pos[2]), res_bus.pos_z);
                check_field("step_mask", want.step_mask, res_bus.step_mask);
                check_field("dir_mask", want.dir_mask, res_bus.dir_mask);
                check_field("stepped", want.stepped, res_bus.stepped);
                check_field("last", want.last, res_bus.last);
                check_field("busy_res", want.busy_res, res_bus.busy_res);
            end
        end
    end

    initial
    begin
        line_req_t  rq;
        line_req_t  tick;
        point_res_t none;
        int         goal;
        int         lim;
        int         off [3];
        int         n_ticks;
        int         r;

        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = bl3d_pkg::REQ_LOAD;
        req_bus.start_x  = '0;
        req_bus.start_y  = '0;
        req_bus.start_z  = '0;
        req_bus.end_x    = '0;
        req_bus.end_y    = '0;
        req_bus.end_z    = '0;
        for (int k = 0; k < 3; k++)
        begin
            cur_pos[k] = '0;
            span[k]    = '0;
        end
        err_term[0]   = '0;
        err_term[1]   = '0;
        steps_to_go   = '0;
        dir_bits      = '0;
        drive_axis    = bl3d_pkg::AXIS_X;
        line_on       = 1'b0;
        n_sent        = 0;
        n_bad         = 0;
        hold_token    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 52;
        none          = '0;
        tick          = '0;
        tick.req_type = bl3d_pkg::REQ_TICK;

        add_row(tick, 1'b1, pt(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(load_req(-32768, 32767, 0, -32768, 32767, 0), 1'b1,
                pt(-32768, 32767, 0, 0, 7, 0, 1, 0));
        add_row(tick, 1'b1, pt(-32768, 32767, 0, 0, 7, 0, 0, 0));
        add_row(load_req(-32768, -32768, -32768, 32767, 0, 32767), 1'b1,
                pt(-32768, -32768, -32768, 0, 0, 0, 0, 1));
        add_row(tick, 1'b0, none);
        add_row(tick, 1'b0, none);
        add_row(load_req(32767, 32767, 32767, -32768, -32768, -32768), 1'b1,
                pt(32767, 32767, 32767, 0, 7, 0, 0, 1));
        add_row(tick, 1'b0, none);
        add_row(load_req(0, 0, 0, 3, 3, 3), 1'b1, pt(0, 0, 0, 0, 0, 0, 0, 1));
        repeat (4)
            add_row(tick, 1'b0, none);
        add_row(load_req(0, 0, 0, 2, -5, 5), 1'b0, none);
        repeat (5)
            add_row(tick, 1'b0, none);
        add_row(load_req(5, 5, 5, 4, 6, 0), 1'b0, none);
        repeat (6)
            add_row(tick, 1'b0, none);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            offer(rows[i].rq, rows[i].typed, rows[i].want);
        drain_results();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 52 : 0;
            recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 25 : 0;
            if (ph != 1)
                hold_token <= hold_token + 1;
            goal = n_sent + 567;
            while (n_sent < goal)
            begin
                r = $urandom_range(99);
                if (r < 78)
                begin
                    lim = ($urandom_range(9) == 0) ? 200 : 12;
                    lim = $urandom_range(0, lim);
                    rq = random_req(bl3d_pkg::REQ_LOAD);
                    n_ticks = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        off[k] = int'($urandom_range(0, 2 * lim)) - lim;
                        rq.to[k] = 16'(int'($signed(rq.from[k])) + off[k]);
                        if (off[k] > n_ticks)
                            n_ticks = off[k];
                        if (-off[k] > n_ticks)
                            n_ticks = -off[k];
                    end
                    n_ticks = n_ticks + $urandom_range(0, 2);
                    if ($urandom_range(9) == 0)
                        n_ticks = $urandom_range(0, n_ticks);
                    offer(rq, 1'b0, none);
                    repeat (n_ticks)
                        offer(random_req(bl3d_pkg::REQ_TICK), 1'b0, none);
                end
                else if (r < 90)
                begin
                    offer(random_req(bl3d_pkg::REQ_LOAD), 1'b0, none);
                    repeat ($urandom_range(0, 6))
                        offer(random_req(bl3d_pkg::REQ_TICK), 1'b0, none);
                end
                else
                    offer(random_req(1'($urandom)), 1'b0, none);
            end
            drain_results();
        end

        repeat (10)
            @(posedge clk);
        if (n_bad == 0)
            $display("tb_bresenham_line_3d_stepper_core OK");
        else
            $display("tb_bresenham_line_3d_stepper_core NOT OK");
        $finish;
    end

endmodule
